### design/dg_pkg.sv
`timescale 1ns / 1ps

package dg_pkg;

  localparam logic [16:0] UNITY = 17'd65536;
  localparam logic [13:0] HYSTERESIS_DB16 = 14'd48;
  localparam logic [22:0] DB16_PER_LOG2_Q16 = 23'd6313057;
  localparam logic [25:0] LOG2_PER_DB16_Q32 = 26'd44586163;
  localparam logic [12:0] DB_FLOOR_MAG = 13'd3200;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_EXPANSION = 3'd1;
  localparam logic [2:0] REG_RANGE = 3'd2;
  localparam logic [2:0] REG_VAD_ENABLE = 3'd3;
  localparam logic [2:0] REG_DET_RISE = 3'd4;
  localparam logic [2:0] REG_DET_FALL = 3'd5;
  localparam logic [2:0] REG_GAIN_OPEN = 3'd6;
  localparam logic [2:0] REG_GAIN_CLOSE = 3'd7;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ENV = 4'd1;
  localparam logic [3:0] ST_LINIT = 4'd2;
  localparam logic [3:0] ST_LNORM = 4'd3;
  localparam logic [3:0] ST_LSQ = 4'd4;
  localparam logic [3:0] ST_LDB = 4'd5;
  localparam logic [3:0] ST_GATE = 4'd6;
  localparam logic [3:0] ST_TMUL = 4'd7;
  localparam logic [3:0] ST_EXP = 4'd8;
  localparam logic [3:0] ST_SHIFT = 4'd9;
  localparam logic [3:0] ST_GMUL = 4'd10;
  localparam logic [3:0] ST_OMUL = 4'd11;
  localparam logic [3:0] ST_OUT = 4'd12;

  function automatic logic [16:0] sat_coeff(input logic [16:0] c);
    return (c > UNITY) ? UNITY : c;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = xin;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q30 factors 2^-(2^-(16-k)) for index k, each the floor square root of the one above it.
  function automatic logic [15:0][31:0] exp_table();
    logic [63:0] c;
    logic [15:0][31:0] tbl;
    c = 64'd1 << 29;
    for (int k = 15; k >= 0; k--) begin
      c = isqrt64(c << 30);
      tbl[k] = c[31:0];
    end
    return tbl;
  endfunction

  localparam logic [15:0][31:0] EXP_C = exp_table();

endpackage

### design/downward_expander_gate.sv
`timescale 1ns / 1ps

// From an accepted request to out_valid the block steps through the normalize shifts, up to
// two 16-step squaring passes and the 16 exponent steps on the shared multiplier.
// in_ready is high only while the block is idle, so no new request is taken until out_valid is accepted.
// Reset (synchronous, active low) restores the default registers, clears the envelope,
// closes the gate and sets the smoothed gain to unity.
module downward_expander_gate import dg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_sample,
  input  logic [7:0]         in_vad_confidence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_sample,
  output logic [16:0]        out_gain,
  output logic signed [12:0] out_gain_meter_db,
  output logic               out_gate_open,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);

  logic [11:0] thr_cfg_r, range_r;
  logic [15:0] ef_r;
  logic        vad_en_r;
  logic [16:0] rise_r, fall_r, gopen_r, gclose_r;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] env_r, env_nxt;
  logic        open_r, open_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic [23:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [12:0] thr_r, thr_nxt;
  logic [31:0] m_r, m_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        which_r, which_nxt;
  logic [12:0] db_r, db_nxt;
  logic [11:0] att_r, att_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] f_r, f_nxt;
  logic [30:0] r_r, r_nxt;
  logic [16:0] target_r, target_nxt;
  logic [23:0] osmp_r, osmp_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [16:0] boost_x;
  logic [30:0] boost_xq;
  logic [8:0]  boost_q0, boost_q;
  logic [16:0] boost_rem;
  logic [23:0] in_mag;

  logic [31:0] level, env_diff, log_src;
  logic        env_up;
  logic [16:0] env_c;
  logic [31:0] env_step;
  logic [31:0] sq;
  logic [20:0] neg_l;
  logic [44:0] d_sum;
  logic [12:0] d_val;
  logic signed [13:0] env_db14, thr14;
  logic        open_n, below_thr;
  logic [13:0] below;
  logic [29:0] red_sum;
  logic [13:0] red_mag;
  logic [11:0] lim;
  logic [36:0] t_sum;
  logic [60:0] e_sum;
  logic [5:0]  sh;
  logic [30:0] sh_val;
  logic [31:0] rnd_val;
  logic        g_up;
  logic [16:0] g_c, g_diff;
  logic [33:0] g_sum;
  logic [17:0] g_new;
  logic [40:0] o_sum;

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  assign boost_x   = 17'({9'd0, in_vad_confidence} * 17'd320) + 17'd127;
  assign boost_xq  = {14'd0, boost_x} * 31'd16448;
  assign boost_q0  = boost_xq[30:22];
  assign boost_rem = boost_x - 17'({8'd0, boost_q0} * 17'd255);
  assign boost_q   = (boost_rem >= 17'd255) ? boost_q0 + 9'd1 : boost_q0;
  assign in_mag    = in_sample[23] ? 24'd0 - in_sample : in_sample;

  assign level    = {mag_r, 8'd0};
  assign env_up   = level > env_r;
  assign env_c    = sat_coeff(env_up ? rise_r : fall_r);
  assign env_diff = env_up ? level - env_r : env_r - level;
  assign env_step = 32'(({16'd0, prod[47:0]} + 64'd65535) >> 16);

  assign log_src = which_r ? {gain_r, 15'd0} : env_r;
  assign sq      = prod[61:30];
  assign neg_l   = {5'd31 - p_r, 16'd0} - {5'd0, frac_r};
  assign d_sum   = prod[44:0] + 45'h80000000;
  assign d_val   = (d_sum[44:32] > DB_FLOOR_MAG) ? DB_FLOOR_MAG : d_sum[44:32];

  assign env_db14  = {db_r[12], db_r};
  assign thr14     = {thr_r[12], thr_r};
  assign open_n    = open_r ? (env_db14 >= thr14 - $signed(HYSTERESIS_DB16))
                            : (env_db14 >= thr14);
  assign below_thr = env_db14 < thr14;
  assign below     = thr14 - env_db14;
  assign red_sum   = prod[29:0] + 30'd32768;
  assign red_mag   = red_sum[29:16];
  assign lim       = range_r[11] ? 12'd0 - range_r : 12'd0;

  assign t_sum = prod[36:0] + 37'd32768;
  assign e_sum = prod[60:0] + (61'd1 << 29);

  assign sh      = 6'd13 + {1'b0, n_r};
  assign sh_val  = r_r >> sh;
  assign rnd_val = {1'b0, sh_val} + 32'd1;

  assign g_up   = target_r > gain_r;
  assign g_c    = sat_coeff(g_up ? gopen_r : gclose_r);
  assign g_diff = g_up ? target_r - gain_r : gain_r - target_r;
  assign g_sum  = prod[33:0] + 34'd65535;
  assign g_new  = g_up ? {1'b0, gain_r} + g_sum[33:16] : {1'b0, gain_r} - g_sum[33:16];

  assign o_sum = prod[40:0] + 41'd32768;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      ST_ENV: begin
        mul_a = env_diff;
        mul_b = {15'd0, env_c};
      end
      ST_LSQ: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      ST_LDB: begin
        mul_a = {11'd0, neg_l};
        mul_b = {9'd0, DB16_PER_LOG2_Q16};
      end
      ST_GATE: begin
        mul_a = {18'd0, below};
        mul_b = {16'd0, ef_r};
      end
      ST_TMUL: begin
        mul_a = {20'd0, att_r};
        mul_b = {6'd0, LOG2_PER_DB16_Q32};
      end
      ST_EXP: begin
        mul_a = {1'b0, r_r};
        mul_b = EXP_C[cnt_r];
      end
      ST_GMUL: begin
        mul_a = {15'd0, g_diff};
        mul_b = {15'd0, g_c};
      end
      ST_OMUL: begin
        mul_a = {8'd0, mag_r};
        mul_b = {15'd0, gain_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    env_nxt    = env_r;
    open_nxt   = open_r;
    gain_nxt   = gain_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    thr_nxt    = thr_r;
    m_nxt      = m_r;
    p_nxt      = p_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    which_nxt  = which_r;
    db_nxt     = db_r;
    att_nxt    = att_r;
    n_nxt      = n_r;
    f_nxt      = f_r;
    r_nxt      = r_r;
    target_nxt = target_r;
    osmp_nxt   = osmp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_sample[23];
          thr_nxt   = {thr_cfg_r[11], thr_cfg_r}
                      - ((vad_en_r && in_vad_confidence != 8'd0) ? {4'd0, boost_q} : 13'd0);
          state_nxt = ST_ENV;
        end
      end
      ST_ENV: begin
        env_nxt   = env_up ? env_r + env_step : env_r - env_step;
        which_nxt = 1'b0;
        state_nxt = ST_LINIT;
      end
      ST_LINIT: begin
        if (log_src == 32'd0) begin
          db_nxt    = 13'd0 - DB_FLOOR_MAG;
          state_nxt = which_r ? ST_OUT : ST_GATE;
        end else begin
          m_nxt     = log_src[31] ? {1'b0, log_src[31:1]} : log_src;
          p_nxt     = log_src[31] ? 5'd31 : 5'd30;
          state_nxt = ST_LNORM;
        end
      end
      ST_LNORM: begin
        if (m_r[30]) begin
          cnt_nxt   = 4'd0;
          frac_nxt  = 16'd0;
          state_nxt = ST_LSQ;
        end else begin
          m_nxt = {m_r[30:0], 1'b0};
          p_nxt = p_r - 5'd1;
        end
      end
      ST_LSQ: begin
        frac_nxt = {frac_r[14:0], sq[31]};
        m_nxt    = sq[31] ? {1'b0, sq[31:1]} : sq;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = ST_LDB;
      end
      ST_LDB: begin
        db_nxt    = 13'd0 - d_val;
        state_nxt = which_r ? ST_OUT : ST_GATE;
      end
      ST_GATE: begin
        open_nxt = open_n;
        if (!open_n && below_thr) begin
          att_nxt = (red_mag > {2'd0, lim}) ? lim : red_mag[11:0];
        end else begin
          att_nxt = 12'd0;
        end
        state_nxt = ST_TMUL;
      end
      ST_TMUL: begin
        n_nxt     = t_sum[36:32];
        f_nxt     = t_sum[31:16];
        r_nxt     = 31'd1 << 30;
        cnt_nxt   = 4'd15;
        state_nxt = ST_EXP;
      end
      ST_EXP: begin
        if (f_r[cnt_r]) r_nxt = e_sum[60:30];
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        target_nxt = rnd_val[17:1];
        state_nxt  = ST_GMUL;
      end
      ST_GMUL: begin
        gain_nxt  = (g_new > {1'b0, UNITY}) ? UNITY : g_new[16:0];
        state_nxt = ST_OMUL;
      end
      ST_OMUL: begin
        osmp_nxt  = neg_r ? 24'd0 - o_sum[39:16] : o_sum[39:16];
        which_nxt = 1'b1;
        state_nxt = ST_LINIT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      env_r     <= 32'd0;
      open_r    <= 1'b0;
      gain_r    <= UNITY;
      thr_cfg_r <= 12'hD80;
      ef_r      <= 16'd32768;
      range_r   <= 12'hD80;
      vad_en_r  <= 1'b0;
      rise_r    <= 17'd65536;
      fall_r    <= 17'd68;
      gopen_r   <= 17'd6553;
      gclose_r  <= 17'd655;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      open_r  <= open_nxt;
      gain_r  <= gain_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_THRESHOLD:  thr_cfg_r <= cfg_wdata[11:0];
          REG_EXPANSION:  ef_r <= cfg_wdata[15:0];
          REG_RANGE:      range_r <= cfg_wdata[11:0];
          REG_VAD_ENABLE: vad_en_r <= cfg_wdata[0];
          REG_DET_RISE:   rise_r <= cfg_wdata;
          REG_DET_FALL:   fall_r <= cfg_wdata;
          REG_GAIN_OPEN:  gopen_r <= cfg_wdata;
          REG_GAIN_CLOSE: gclose_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    thr_r    <= thr_nxt;
    m_r      <= m_nxt;
    p_r      <= p_nxt;
    frac_r   <= frac_nxt;
    cnt_r    <= cnt_nxt;
    which_r  <= which_nxt;
    db_r     <= db_nxt;
    att_r    <= att_nxt;
    n_r      <= n_nxt;
    f_r      <= f_nxt;
    r_r      <= r_nxt;
    target_r <= target_nxt;
    osmp_r   <= osmp_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_sample        = osmp_r;
  assign out_gain          = gain_r;
  assign out_gain_meter_db = db_r;
  assign out_gate_open     = open_r;

endmodule
